/* rtl/bba_pkg.sv */
// shared constants, types and address helpers for the buddy block allocator
package bba_pkg;

  localparam int NumOrders     = 8;
  localparam int TopOrder      = NumOrders - 1;
  localparam int OrderW        = 3;
  localparam int UnitDepth     = 512;
  localparam int UnitW         = 9;
  localparam int LenW          = UnitW + 1;
  localparam int EntDepth      = 2 * UnitDepth - (2 * UnitDepth >> NumOrders);
  localparam int EntAw         = 10;
  localparam int MaxChunks     = 4;
  localparam int ChunkW        = 3;
  localparam int ChunkUnitShift = 7;
  localparam int MinBlockShift = 4;
  localparam int HeaderBytes   = 16;
  localparam int ChunkBytes    = 2048;
  localparam int AddrW         = 13;
  localparam int ReqW          = 16;
  localparam int SizeW         = ReqW + 1;
  localparam int StatW         = 2;

  localparam logic [StatW-1:0] StatOk       = 2'd0;
  localparam logic [StatW-1:0] StatTooLarge = 2'd1;
  localparam logic [StatW-1:0] StatNoMem    = 2'd2;

  localparam logic FuncAlloc = 1'b0;
  localparam logic FuncFree  = 1'b1;

  typedef struct packed {
    logic              busy;
    logic [OrderW-1:0] order;
  } unit_rec_t;

  // mask that wraps a ring position inside the list of order k
  function automatic logic [UnitW-1:0] ring_mask(input logic [OrderW-1:0] k);
    return {UnitW{1'b1}} >> k;
  endfunction

  // memory address of position pos in the ring list of order k
  function automatic logic [EntAw-1:0] ent_addr(input logic [OrderW-1:0] k,
                                                input logic [UnitW-1:0]  head,
                                                input logic [UnitW-1:0]  pos);
    logic [EntAw:0]   base;
    logic [UnitW-1:0] idx;
    base = (EntAw+1)'(2 * UnitDepth) - ((EntAw+1)'(2 * UnitDepth) >> k);
    idx  = (head + pos) & ring_mask(k);
    return EntAw'(base) + EntAw'(idx);
  endfunction

  // smallest order whose block holds size bytes, capped at the top order
  function automatic logic [OrderW-1:0] order_fit(input logic [SizeW-1:0] size);
    logic [OrderW-1:0] k;
    k = OrderW'(TopOrder);
    for (int i = NumOrders - 1; i >= 0; i--) begin
      if ((SizeW'(1) << (i + MinBlockShift)) >= size) begin
        k = OrderW'(i);
      end
    end
    return k;
  endfunction

endpackage

/* rtl/bba_ram.sv */
// single write port, single registered read port ram
module bba_ram #(
  parameter int Width = 8,
  parameter int Depth = 256,
  parameter int AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/buddy_block_allocator.sv */
// buddy block allocator top level: request sequencer over free-list and block-tag rams
//
//   channel | direction | handshake            | payload
//   in      | input     | in_valid_i/in_stall_o | func_i, request_bytes_i, free_address_i
//   out     | output    | out_valid_o/out_stall_i | address_o, status_o
//
// one transaction at a time; allocate: start, check, pop read, tag write, and per split
// level a read and two writes; free: start, tag check, merge test, append, with a read
// per entry searched and a read and write per entry shifted; a rejected free skips to done
// every list access goes through the free-list ram, whose read port is registered
// after reset all 512 block-tag ram entries are cleared while in_stall_o is high
// a finished result waits in the output register; a new transaction is taken meanwhile
module buddy_block_allocator (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        func_i,
  input  logic [bba_pkg::ReqW-1:0]    request_bytes_i,
  input  logic [bba_pkg::AddrW-1:0]   free_address_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [bba_pkg::AddrW-1:0]   address_o,
  output logic [bba_pkg::StatW-1:0]   status_o
);
  import bba_pkg::*;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_A_START, S_A_CHK, S_SPLIT_RD, S_SPLIT_W0, S_SPLIT_W1,
    S_POP_RD, S_POP_W, S_F_START, S_F_CHK, S_M_TEST, S_M_RD, S_M_CMP,
    S_SH_RD, S_SH_W, S_F_APP, S_DONE
  } state_e;

  state_e state_q, state_d;

  logic [LenW-1:0]   lens_q  [NumOrders];
  logic [LenW-1:0]   lens_d  [NumOrders];
  logic [UnitW-1:0]  heads_q [NumOrders];
  logic [UnitW-1:0]  heads_d [NumOrders];
  logic [ChunkW-1:0] chunks_q, chunks_d;
  logic [UnitW-1:0]  clr_q, clr_d;
  logic              out_valid_q, out_valid_d;

  logic              func_q, func_d;
  logic [ReqW-1:0]   req_q, req_d;
  logic [AddrW-1:0]  faddr_q, faddr_d;
  logic [UnitW-1:0]  u_q, u_d;
  logic [OrderW-1:0] k_q, k_d;
  logic [OrderW-1:0] lvl_q, lvl_d;
  logic [UnitW-1:0]  p_q, p_d;
  logic [AddrW-1:0]  res_addr_q, res_addr_d;
  logic [StatW-1:0]  res_stat_q, res_stat_d;
  logic [AddrW-1:0]  addr_out_q, addr_out_d;
  logic [StatW-1:0]  stat_out_q, stat_out_d;

  // ram ports
  logic              fl_we, fl_re;
  logic [EntAw-1:0]  fl_waddr, fl_raddr;
  logic [UnitW-1:0]  fl_wdata, fl_rdata;
  logic              un_we, un_re;
  logic [UnitW-1:0]  un_waddr, un_raddr;
  unit_rec_t         un_wdata, un_rdata;

  // derived values
  logic [SizeW-1:0]  size;
  logic [OrderW-1:0] kfit;
  logic [OrderW-1:0] big;
  logic              big_found;
  logic              any_free;
  logic [AddrW-1:0]  off;
  logic [UnitW-1:0]  off_unit;
  logic [LenW-1:0]   limit;
  logic [UnitW-1:0]  buddy;
  logic [UnitW-1:0]  chunk_unit;

  assign size       = SizeW'(req_q) + SizeW'(HeaderBytes);
  assign kfit       = order_fit(size);
  assign off        = faddr_q - AddrW'(HeaderBytes);
  assign off_unit   = off[AddrW-1:MinBlockShift];
  assign limit      = LenW'(chunks_q) << ChunkUnitShift;
  assign buddy      = u_q ^ (UnitW'(1) << k_q);
  assign chunk_unit = UnitW'(chunks_q) << ChunkUnitShift;

  always_comb begin
    big       = OrderW'(TopOrder);
    big_found = 1'b0;
    any_free  = 1'b0;
    for (int i = NumOrders - 1; i >= 0; i--) begin
      if (lens_q[i] != '0) begin
        any_free = 1'b1;
        if (OrderW'(i) > kfit) begin
          big       = OrderW'(i);
          big_found = 1'b1;
        end
      end
    end
  end

  always_comb begin
    state_d     = state_q;
    lens_d      = lens_q;
    heads_d     = heads_q;
    chunks_d    = chunks_q;
    clr_d       = clr_q;
    out_valid_d = out_valid_q;
    func_d      = func_q;
    req_d       = req_q;
    faddr_d     = faddr_q;
    u_d         = u_q;
    k_d         = k_q;
    lvl_d       = lvl_q;
    p_d         = p_q;
    res_addr_d  = res_addr_q;
    res_stat_d  = res_stat_q;
    addr_out_d  = addr_out_q;
    stat_out_d  = stat_out_q;
    fl_we       = 1'b0;
    fl_waddr    = '0;
    fl_wdata    = '0;
    fl_re       = 1'b0;
    fl_raddr    = '0;
    un_we       = 1'b0;
    un_waddr    = '0;
    un_wdata    = '0;
    un_re       = 1'b0;
    un_raddr    = '0;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_CLEAR: begin
        un_we    = 1'b1;
        un_waddr = clr_q;
        clr_d    = clr_q + UnitW'(1);
        if (clr_q == {UnitW{1'b1}}) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          func_d  = func_i;
          req_d   = request_bytes_i;
          faddr_d = free_address_i;
          state_d = (func_i == FuncFree) ? S_F_START : S_A_START;
        end
      end
      S_A_START: begin
        res_addr_d = '0;
        if (size > SizeW'(ChunkBytes)) begin
          res_stat_d = StatTooLarge;
          state_d    = S_DONE;
        end else begin
          if (chunks_q == '0) begin
            // first use claims chunk 0
            fl_we    = 1'b1;
            fl_waddr = ent_addr(OrderW'(TopOrder), heads_q[TopOrder],
                                lens_q[TopOrder][UnitW-1:0]);
            fl_wdata = chunk_unit;
            lens_d[TopOrder] = lens_q[TopOrder] + LenW'(1);
            chunks_d = chunks_q + ChunkW'(1);
          end
          state_d = S_A_CHK;
        end
      end
      S_A_CHK: begin
        if (!any_free) begin
          res_stat_d = StatNoMem;
          state_d    = S_DONE;
        end else if (lens_q[kfit] != '0) begin
          state_d = S_POP_RD;
        end else if (big_found) begin
          lvl_d   = big;
          state_d = S_SPLIT_RD;
        end else if (chunks_q >= ChunkW'(MaxChunks)) begin
          res_stat_d = StatNoMem;
          state_d    = S_DONE;
        end else begin
          fl_we    = 1'b1;
          fl_waddr = ent_addr(OrderW'(TopOrder), heads_q[TopOrder],
                              lens_q[TopOrder][UnitW-1:0]);
          fl_wdata = chunk_unit;
          lens_d[TopOrder] = lens_q[TopOrder] + LenW'(1);
          chunks_d = chunks_q + ChunkW'(1);
          lvl_d    = OrderW'(TopOrder);
          // a whole-chunk request takes the new chunk without splitting
          state_d  = (kfit == OrderW'(TopOrder)) ? S_POP_RD : S_SPLIT_RD;
        end
      end
      S_SPLIT_RD: begin
        fl_re    = 1'b1;
        fl_raddr = ent_addr(lvl_q, heads_q[lvl_q], '0);
        heads_d[lvl_q] = (heads_q[lvl_q] + UnitW'(1)) & ring_mask(lvl_q);
        lens_d[lvl_q]  = lens_q[lvl_q] - LenW'(1);
        state_d  = S_SPLIT_W0;
      end
      S_SPLIT_W0: begin
        // lower half goes in first
        u_d      = fl_rdata;
        fl_we    = 1'b1;
        fl_waddr = ent_addr(lvl_q - OrderW'(1), heads_q[lvl_q - OrderW'(1)],
                            lens_q[lvl_q - OrderW'(1)][UnitW-1:0]);
        fl_wdata = fl_rdata;
        lens_d[lvl_q - OrderW'(1)] = lens_q[lvl_q - OrderW'(1)] + LenW'(1);
        state_d  = S_SPLIT_W1;
      end
      S_SPLIT_W1: begin
        fl_we    = 1'b1;
        fl_waddr = ent_addr(lvl_q - OrderW'(1), heads_q[lvl_q - OrderW'(1)],
                            lens_q[lvl_q - OrderW'(1)][UnitW-1:0]);
        fl_wdata = u_q + (UnitW'(1) << (lvl_q - OrderW'(1)));
        lens_d[lvl_q - OrderW'(1)] = lens_q[lvl_q - OrderW'(1)] + LenW'(1);
        lvl_d    = lvl_q - OrderW'(1);
        state_d  = (lvl_q - OrderW'(1) == kfit) ? S_POP_RD : S_SPLIT_RD;
      end
      S_POP_RD: begin
        fl_re    = 1'b1;
        fl_raddr = ent_addr(kfit, heads_q[kfit], '0);
        heads_d[kfit] = (heads_q[kfit] + UnitW'(1)) & ring_mask(kfit);
        lens_d[kfit]  = lens_q[kfit] - LenW'(1);
        state_d  = S_POP_W;
      end
      S_POP_W: begin
        un_we          = 1'b1;
        un_waddr       = fl_rdata;
        un_wdata.busy  = 1'b1;
        un_wdata.order = kfit;
        res_addr_d     = (AddrW'(fl_rdata) << MinBlockShift) + AddrW'(HeaderBytes);
        res_stat_d     = StatOk;
        state_d        = S_DONE;
      end
      S_F_START: begin
        res_addr_d = '0;
        res_stat_d = StatOk;
        if (off[MinBlockShift-1:0] != '0 || LenW'(off_unit) >= limit) begin
          state_d = S_DONE;
        end else begin
          un_re    = 1'b1;
          un_raddr = off_unit;
          u_d      = off_unit;
          state_d  = S_F_CHK;
        end
      end
      S_F_CHK: begin
        if (!un_rdata.busy) begin
          state_d = S_DONE;
        end else begin
          un_we          = 1'b1;
          un_waddr       = u_q;
          un_wdata.busy  = 1'b0;
          un_wdata.order = un_rdata.order;
          k_d            = un_rdata.order;
          state_d        = S_M_TEST;
        end
      end
      S_M_TEST: begin
        if (k_q == OrderW'(TopOrder) || LenW'(buddy) >= limit || lens_q[k_q] == '0) begin
          state_d = S_F_APP;
        end else begin
          p_d     = '0;
          state_d = S_M_RD;
        end
      end
      S_M_RD: begin
        fl_re    = 1'b1;
        fl_raddr = ent_addr(k_q, heads_q[k_q], p_q);
        state_d  = S_M_CMP;
      end
      S_M_CMP: begin
        if (fl_rdata == buddy) begin
          if (LenW'(p_q) + LenW'(1) == lens_q[k_q]) begin
            lens_d[k_q] = lens_q[k_q] - LenW'(1);
            u_d         = (buddy < u_q) ? buddy : u_q;
            k_d         = k_q + OrderW'(1);
            state_d     = S_M_TEST;
          end else begin
            state_d = S_SH_RD;
          end
        end else if (LenW'(p_q) + LenW'(1) == lens_q[k_q]) begin
          state_d = S_F_APP;
        end else begin
          p_d     = p_q + UnitW'(1);
          state_d = S_M_RD;
        end
      end
      S_SH_RD: begin
        // close the gap: entry after the hole moves down one place
        fl_re    = 1'b1;
        fl_raddr = ent_addr(k_q, heads_q[k_q], p_q + UnitW'(1));
        state_d  = S_SH_W;
      end
      S_SH_W: begin
        fl_we    = 1'b1;
        fl_waddr = ent_addr(k_q, heads_q[k_q], p_q);
        fl_wdata = fl_rdata;
        p_d      = p_q + UnitW'(1);
        if (LenW'(p_q) + LenW'(2) == lens_q[k_q]) begin
          lens_d[k_q] = lens_q[k_q] - LenW'(1);
          u_d         = (buddy < u_q) ? buddy : u_q;
          k_d         = k_q + OrderW'(1);
          state_d     = S_M_TEST;
        end else begin
          state_d = S_SH_RD;
        end
      end
      S_F_APP: begin
        fl_we    = 1'b1;
        fl_waddr = ent_addr(k_q, heads_q[k_q], lens_q[k_q][UnitW-1:0]);
        fl_wdata = u_q;
        lens_d[k_q] = lens_q[k_q] + LenW'(1);
        state_d  = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          addr_out_d  = (func_q == FuncFree) ? '0 : res_addr_q;
          stat_out_d  = (func_q == FuncFree) ? StatOk : res_stat_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      chunks_q    <= '0;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < NumOrders; i++) begin
        lens_q[i]  <= '0;
        heads_q[i] <= '0;
      end
    end else begin
      state_q     <= state_d;
      chunks_q    <= chunks_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
      lens_q      <= lens_d;
      heads_q     <= heads_d;
    end
  end

  always_ff @(posedge clk_i) begin
    func_q     <= func_d;
    req_q      <= req_d;
    faddr_q    <= faddr_d;
    u_q        <= u_d;
    k_q        <= k_d;
    lvl_q      <= lvl_d;
    p_q        <= p_d;
    res_addr_q <= res_addr_d;
    res_stat_q <= res_stat_d;
    addr_out_q <= addr_out_d;
    stat_out_q <= stat_out_d;
  end

  bba_ram #(
    .Width (UnitW),
    .Depth (EntDepth)
  ) u_free_ram (
    .clk_i   (clk_i),
    .we_i    (fl_we),
    .waddr_i (fl_waddr),
    .wdata_i (fl_wdata),
    .re_i    (fl_re),
    .raddr_i (fl_raddr),
    .rdata_o (fl_rdata)
  );

  bba_ram #(
    .Width ($bits(unit_rec_t)),
    .Depth (UnitDepth)
  ) u_unit_ram (
    .clk_i   (clk_i),
    .we_i    (un_we),
    .waddr_i (un_waddr),
    .wdata_i (un_wdata),
    .re_i    (un_re),
    .raddr_i (un_raddr),
    .rdata_o (un_rdata)
  );

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign address_o   = addr_out_q;
  assign status_o    = stat_out_q;

  a_chunks_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    chunks_q <= ChunkW'(MaxChunks))
    else $error("more chunks claimed than the heap holds");

  a_top_list_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lens_q[TopOrder] <= LenW'(MaxChunks))
    else $error("top order list longer than the chunk count");

  a_err_addr_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != StatOk |-> address_o == '0)
    else $error("error result carries an address");

  a_stat_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o == StatOk || status_o == StatTooLarge || status_o == StatNoMem)
    else $error("undefined status code");

endmodule
